FILE: design/kgsr_pkg.sv
`timescale 1ns / 1ps

package kgsr_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned SizeWidth  = 5;
    localparam logic [SizeWidth-1:0] GroupSizeReset = 5'd3;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value_in;
        logic                         final_in;
    } t_in_beat;

    typedef struct packed {
        logic signed [ValueWidth-1:0] value_out;
        logic                         final_out;
    } t_out_beat;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic step;
    } t_kgsr_cmd;

    // datapath to controller
    typedef struct packed {
        logic flush;
        logic left_one;
        logic out_free;
    } t_kgsr_status;

endpackage

FILE: design/kgsr_datapath.sv
`timescale 1ns / 1ps

module kgsr_datapath import kgsr_pkg::*; #(
    parameter int unsigned MAX_GROUP = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SizeWidth-1:0] i_cfg_wdata,
    input  t_in_beat             i_in_data,
    input  logic                 i_out_ready,
    input  t_kgsr_cmd            i_cmd,
    output t_kgsr_status         o_status,
    output logic                 o_out_valid,
    output t_out_beat            o_out_data
);

    localparam int unsigned AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int unsigned CW = $clog2(MAX_GROUP + 1);

    logic [ValueWidth-1:0] r_mem [MAX_GROUP];

    logic [SizeWidth-1:0] r_group_size;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_left;
    logic [AW-1:0]        r_ptr;
    logic                 r_down;
    logic                 r_last;
    logic                 r_out_valid;
    logic [ValueWidth-1:0] r_out_value;
    logic                 r_out_final;

    logic [CW-1:0] n_count;
    logic [CW-1:0] n_eff_size;
    logic          n_full;

    // clamp the configured size to 1..MAX_GROUP
    always_comb begin
        if (r_group_size == '0) begin
            n_eff_size = CW'(1);
        end else if (32'(r_group_size) > 32'(MAX_GROUP)) begin
            n_eff_size = CW'(MAX_GROUP);
        end else begin
            n_eff_size = CW'(r_group_size);
        end
    end

    assign n_count = r_fill + CW'(1);
    assign n_full  = (n_count >= n_eff_size);

    assign o_status.flush    = n_full || i_in_data.final_in;
    assign o_status.left_one = (r_left == CW'(1));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GroupSizeReset;
        end else if (i_cfg_we) begin
            r_group_size <= i_cfg_wdata;
        end
    end

    // write the accepted value into the group buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_fill[AW-1:0]] <= i_in_data.value_in;
        end
    end

    // fill count and drain pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_left <= '0;
            r_ptr  <= '0;
            r_down <= 1'b0;
            r_last <= 1'b0;
        end else if (i_cmd.accept) begin
            r_last <= i_in_data.final_in;
            if (n_full) begin
                r_fill <= '0;
                r_left <= n_count;
                r_ptr  <= r_fill[AW-1:0];
                r_down <= 1'b1;
            end else if (i_in_data.final_in) begin
                r_fill <= '0;
                r_left <= n_count;
                r_ptr  <= '0;
                r_down <= 1'b0;
            end else begin
                r_fill <= n_count;
            end
        end else if (i_cmd.step) begin
            r_left <= r_left - CW'(1);
            r_ptr  <= r_down ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
        end
    end

    // read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_value <= r_mem[r_ptr];
            r_out_final <= r_last && (r_left == CW'(1));
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_out_data.value_out = r_out_value;
    assign o_out_data.final_out = r_out_final;

endmodule

FILE: design/kgsr_ctrl.sv
`timescale 1ns / 1ps

module kgsr_ctrl import kgsr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_kgsr_status i_status,
    output logic         o_in_ready,
    output t_kgsr_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.step   = 1'b0;
        case (r_state)
            ST_FILL: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.flush) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // advance one beat whenever the output register frees up
                o_cmd.step = i_status.out_free;
                if (i_status.out_free && i_status.left_one) begin
                    n_state = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

endmodule

FILE: design/k_group_stream_reverser.sv
`timescale 1ns / 1ps

// k_group_stream_reverser
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one signed 32-bit
// value per beat with a final flag on the last value of a sequence. Values are
// gathered into groups of group_size (written through i_cfg_we / i_cfg_wdata,
// 0 acts as 1, sizes above MAX_GROUP act as MAX_GROUP). A full group leaves on
// the output channel (o_out_valid / i_out_ready / o_out_data) in reverse order;
// a short group closed by a final beat leaves in arrival order. The last result
// of a sequence carries final_out.
// Throughput: one input beat per cycle while a group fills; once the group
// closes, input is held off and the buffer drains one result per cycle while
// the output takes them. The buffer has a single read port, which sets the
// one-result-per-cycle drain rate. The beat that closes a group moves the
// controller into its drain state; the first result is then registered into
// the output, later if an earlier result still waits on the output.
// A stall on the output holds the current result and pauses the drain.
// Reset clears the fill count, sets group_size to 3 and empties the output.
module k_group_stream_reverser import kgsr_pkg::*; #(
    parameter int unsigned MAX_GROUP = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SizeWidth-1:0] i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_beat            o_out_data
);

    t_kgsr_cmd    w_cmd;
    t_kgsr_status w_status;

    kgsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    kgsr_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: design/kgsr_checker.sv
`timescale 1ns / 1ps

module kgsr_checker import kgsr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    // a pending result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // a final input always closes a group, so input is held off next
    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.final_in |=> !o_in_ready)
        else $error("final beat accepted without draining");

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind k_group_stream_reverser kgsr_checker u_kgsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import kgsr_pkg::*;

    localparam int unsigned MaxGroup   = 16;
    localparam int unsigned CycleLimit = 300000;
    localparam int unsigned HoldOff    = 90;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [SizeWidth-1:0] cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    t_in_beat             in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out_beat            out_data;

    // beats waiting to be offered, and results still owed by the block
    t_in_beat  source_beats[$];
    t_out_beat reordered_values[$];

    // predictor state
    logic signed [ValueWidth-1:0] held_values [MaxGroup];
    int unsigned                  held_count;
    logic [SizeWidth-1:0]         group_size_reg;

    int unsigned error_count;
    int unsigned cycle_count;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_off_cycles;
    logic        calm;
    logic        hold_off_req;

    k_group_stream_reverser #(
        .MAX_GROUP(MaxGroup)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // stop a hung run
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Take one accepted beat, append whatever results it releases.
    task automatic reverse_into_groups(input t_in_beat beat);
        int unsigned eff_size;
        int unsigned count;
        t_out_beat   res;
        eff_size = (group_size_reg == '0) ? 1 :
                   (group_size_reg > MaxGroup) ? MaxGroup : int'(group_size_reg);
        if (held_count >= MaxGroup)
            held_count = MaxGroup - 1;
        held_values[held_count] = beat.value_in;
        count = held_count + 1;
        if (count >= eff_size) begin
            // full group: newest first
            for (int unsigned i = 0; i < count; i++) begin
                res.value_out = held_values[count - 1 - i];
                res.final_out = beat.final_in && (i == count - 1);
                reordered_values.push_back(res);
            end
            held_count = 0;
        end else if (beat.final_in) begin
            // short group closed by final: arrival order
            for (int unsigned i = 0; i < count; i++) begin
                res.value_out = held_values[i];
                res.final_out = (i == count - 1);
                reordered_values.push_back(res);
            end
            held_count = 0;
        end else begin
            held_count = count;
        end
    endtask

    // Driver: offer queued beats, predict on each accepted one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end else begin
            if (in_valid && in_ready)
                reverse_into_groups(in_data);
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end else if (!calm && source_beats.size() != 0 &&
                             $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end else if (source_beats.size() != 0) begin
                    in_valid <= 1'b1;
                    in_data  <= source_beats.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, drive ready with stalls.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_gap = 0;
            hold_off_cycles = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (reordered_values.size() == 0) begin
                    $display("%0t: unexpected result, actual value %0d final %0b",
                             $time, out_data.value_out, out_data.final_out);
                    error_count = error_count + 1;
                end else begin
                    want = reordered_values.pop_front();
                    if (out_data.value_out !== want.value_out) begin
                        $display("%0t: value_out mismatch, expected %0d, actual %0d",
                                 $time, want.value_out, out_data.value_out);
                        error_count = error_count + 1;
                    end
                    if (out_data.final_out !== want.final_out) begin
                        $display("%0t: final_out mismatch, expected %0b, actual %0b",
                                 $time, want.final_out, out_data.final_out);
                        error_count = error_count + 1;
                    end
                end
            end
            if (hold_off_req && hold_off_cycles < HoldOff) begin
                // one long stall so the block backs up into its input
                hold_off_cycles = hold_off_cycles + 1;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                recv_gap = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [ValueWidth-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_beat(input logic signed [ValueWidth-1:0] v, input logic fin);
        t_in_beat beat;
        beat.value_in = v;
        beat.final_in = fin;
        source_beats.push_back(beat);
    endtask

    // Queue sequences of random length; the last one may stay open.
    task automatic queue_stream(input int unsigned n_items, input int unsigned max_len,
                                input logic close_last);
        int unsigned left;
        int unsigned len;
        logic        fin;
        left = n_items;
        while (left > 0) begin
            len = $urandom_range(1, max_len);
            if (len > left)
                len = left;
            left = left - len;
            for (int unsigned i = 0; i < len; i++) begin
                fin = (i == len - 1);
                if (left == 0 && !close_last)
                    fin = fin && $urandom_range(0, 1);
                push_beat(pick_value(), fin);
            end
        end
    endtask

    // Hold until everything is sent and every result is back.
    task automatic wait_drained();
        while (source_beats.size() != 0 || in_valid || reordered_values.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_group_size(input logic [SizeWidth-1:0] sz);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= sz;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        group_size_reg = sz;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        calm           = 1'b0;
        hold_off_req   = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        held_count     = 0;
        group_size_reg = GroupSizeReset;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size 3: full group reversed, short group in order, full group with final
        push_beat(32'sh7FFF_FFFF, 1'b0);
        push_beat(32'sh8000_0000, 1'b0);
        push_beat(32'sd0, 1'b0);
        push_beat(-32'sd1, 1'b0);
        push_beat(32'sd1, 1'b1);
        push_beat(32'sd5, 1'b0);
        push_beat(32'sd6, 1'b0);
        push_beat(32'sd7, 1'b1);

        // size zero acts as one
        write_group_size(5'd0);
        push_beat(32'sd10, 1'b0);
        push_beat(32'sd11, 1'b1);

        write_group_size(5'd1);
        push_beat(32'sd12, 1'b1);

        // shrink the size while a group is half full
        write_group_size(5'd5);
        push_beat(32'sd20, 1'b0);
        push_beat(32'sd21, 1'b0);
        push_beat(32'sd22, 1'b0);
        write_group_size(5'd2);
        push_beat(32'sd23, 1'b0);

        // largest size, closed early by final
        write_group_size(5'd16);
        push_beat(32'sd30, 1'b0);
        push_beat(32'sd31, 1'b1);

        // random part; the first phase runs under a long output stall
        write_group_size(5'd16);
        hold_off_req <= 1'b1;
        queue_stream(30, 40, 1'b0);
        write_group_size(5'd31);
        queue_stream(10, 20, 1'b0);
        write_group_size(5'd2);
        queue_stream(15, 6, 1'b0);
        write_group_size(5'd17);
        queue_stream(15, 24, 1'b0);
        write_group_size(5'd0);
        queue_stream(8, 4, 1'b0);
        repeat (2) begin
            write_group_size(SizeWidth'($urandom_range(1, 15)));
            queue_stream(10, 12, 1'b0);
        end

        // last stretch without idling
        write_group_size(SizeWidth'($urandom_range(1, 16)));
        calm <= 1'b1;
        queue_stream(12, 10, 1'b1);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (reordered_values.size() != 0)
            $display("%0t: %0d expected results never arrived", $time,
                     reordered_values.size());
        if (error_count == 0 && reordered_values.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
